FILE: rtl/ohf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohf_pkg: shared types and constants for the odometry/IMU heading fusion
// Angle constants in Q3.28 radians, CORDIC arctangent table, field widths.
// ----------------------------------------------------------------------------
package ohf_pkg;

  localparam int ITEM_W = 96;   // in_tdata / out_tdata width
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 22;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_ODO_WEIGHT    = 2'd0,
    CFG_TICKS_PER_TURN = 2'd1,
    CFG_WHEEL_CIRC    = 2'd2,
    CFG_WHEEL_SPACING = 2'd3
  } cfg_idx_t;

  // divider chains
  localparam int ODIV_STEPS = 40;  // odometric turn quotient bits
  localparam int ODIV_DW    = 38;  // ticks * spacing
  localparam int MDIV_STEPS = 53;  // mean distance quotient bits
  localparam int MDIV_DW    = 16;  // ticks per turn

  // CORDIC datapath widths
  localparam int XW = 33;
  localparam int ZW = 32;

  localparam logic signed [31:0] Q28_PI          = 32'sd843314857;
  localparam logic signed [31:0] Q28_HALF_PI     = 32'sd421657428;
  localparam logic signed [31:0] Q28_TWO_PI      = 32'sd1686629713;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032875;

  // atan(2^-i) in Q28
  localparam logic signed [ZW-1:0] ATAN_Q28 [32] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2,
    32'sd1,         32'sd1,         32'sd0,        32'sd0
  };

endpackage

FILE: rtl/ohf_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohf_div_cell: one restoring division step
// Brings in the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit in. Cells are chained, one per quotient bit.
// ----------------------------------------------------------------------------
module ohf_div_cell #(
  parameter int DW = 16,
  parameter int NW = 53,
  parameter int QW = 53
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] divisor,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [QW-1:0] quo_i,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [QW-1:0] quo_r, quo_nxt;

  always_comb begin
    trial   = {rem_i, num_i[NW-1]};
    diff    = trial - {1'b0, divisor};
    take    = (trial >= {1'b0, divisor});
    rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];
    num_nxt = {num_i[NW-2:0], 1'b0};
    quo_nxt = {quo_i[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;

endmodule

FILE: rtl/ohf_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohf_cordic_cell: one CORDIC rotation step
// Rotates (x, y) by +/- atan(2^-STEP) toward a zero residual angle z.
// ----------------------------------------------------------------------------
module ohf_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ohf_pkg::XW-1:0] x_i,
  input  logic signed [ohf_pkg::XW-1:0] y_i,
  input  logic signed [ohf_pkg::ZW-1:0] z_i,
  output logic signed [ohf_pkg::XW-1:0] x_o,
  output logic signed [ohf_pkg::XW-1:0] y_o,
  output logic signed [ohf_pkg::ZW-1:0] z_o
);

  import ohf_pkg::*;

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_Q28[STEP];
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_Q28[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

FILE: rtl/ohf_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohf_delay: enabled shift line
// Carries side data alongside the divider and CORDIC chains.
// ----------------------------------------------------------------------------
module ohf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign d_o = sr_r[DEPTH-1];

endmodule

FILE: rtl/odometry_imu_heading_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_imu_heading_fusion: differential-drive odometry with IMU yaw blend
// Wheel distances, odometric turn, complementary heading blend and CORDIC
// projection of the mean distance at the mid heading.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata, low bit up)
//  in_      in   left_ticks[16] right_ticks[16] imu_yaw_delta[32] prev_heading[32]
//  out_     out  move_x_um[32] move_y_um[32] heading_delta[32]
//  cfg_     in   wr_en, addr (register index), wr_data[22]
//
//  One item per cycle while the output is not stalled. The pipe length is set
//  by the 40-cell turn divider and the CORDIC cell row.
//  rst_n is synchronous; it clears valid bits and loads register defaults.
//  A stalled output freezes the pipe unless its last stage holds a bubble.
// ----------------------------------------------------------------------------
module odometry_imu_heading_fusion #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // left_ticks, right_ticks, imu_yaw_delta, prev_heading
  input  logic [ohf_pkg::ITEM_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // move_x_um, move_y_um, heading_delta
  output logic [ohf_pkg::ITEM_W-1:0]  out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [ohf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ohf_pkg::CFG_DW-1:0]  cfg_wr_data
);

  import ohf_pkg::*;

  localparam int NSTG  = 50 + CORDIC_STEPS;   // pipeline stages before output
  localparam int MDLY  = CORDIC_STEPS - 8;    // mean quotient wait
  localparam int SDLY  = 45 + CORDIC_STEPS;   // mean sign wait
  localparam int HDLY  = CORDIC_STEPS + 5;    // heading delta wait
  localparam int ST_M1 = 45;
  localparam int ST_M3 = 47;

  localparam logic signed [43:0] S32_MAX = 44'sd2147483647;
  localparam logic signed [43:0] S32_MIN = -44'sd2147483648;

  // ---------------- configuration ----------------
  logic [16:0] weight_r;
  logic [15:0] tpt_r;
  logic [21:0] circ_r;
  logic [21:0] spacing_r;
  logic [15:0] tpt_eff_r, tpt_eff;
  logic [21:0] spc_eff;
  logic [37:0] d_r, d_nxt;
  logic [16:0] w_eff_r, w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r  <= 17'd65536;
      tpt_r     <= 16'd4096;
      circ_r    <= 22'd200000;
      spacing_r <= 22'd300000;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ODO_WEIGHT:     weight_r  <= cfg_wr_data[16:0];
        CFG_TICKS_PER_TURN: tpt_r     <= cfg_wr_data[15:0];
        CFG_WHEEL_CIRC:     circ_r    <= cfg_wr_data;
        CFG_WHEEL_SPACING:  spacing_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tpt_eff = (tpt_r == '0) ? 16'd1 : tpt_r;
    spc_eff = (spacing_r == '0) ? 22'd1 : spacing_r;
    w_eff   = (weight_r > 17'd65536) ? 17'd65536 : weight_r;
    d_nxt   = tpt_eff * spc_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpt_eff_r <= 16'd4096;
      d_r       <= 38'd1228800000;
      w_eff_r   <= 17'd65536;
    end else begin
      tpt_eff_r <= tpt_eff;
      d_r       <= d_nxt;
      w_eff_r   <= w_eff;
    end
  end

  // ---------------- flow control ----------------
  logic            en;
  logic [NSTG-1:0] v_r;
  logic            out_valid_r;
  logic            out_load;

  assign en        = !out_valid_r || out_tready || !v_r[NSTG-1];
  assign in_tready = en;
  assign out_load  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_tvalid};
    end
  end

  // ---------------- s0: input capture ----------------
  logic signed [15:0] left_r, right_r;
  logic signed [31:0] imu_r, prev_r;

  always_ff @(posedge clk) begin
    if (en) begin
      left_r  <= in_tdata[15:0];
      right_r <= in_tdata[31:16];
      imu_r   <= in_tdata[63:32];
      prev_r  <= in_tdata[95:64];
    end
  end

  // ---------------- s1: tick sums, distance products ----------------
  logic signed [16:0] sum_s, diff_s;
  logic [16:0]        sum_abs, diff_abs;
  logic [38:0]        n1_full, n2_full;
  logic [37:0]        n1_r, n2_r;
  logic               sneg1_r, dneg1_r;
  logic signed [31:0] imu1_r, prev1_r;

  always_comb begin
    sum_s    = 17'(left_r) + 17'(right_r);
    diff_s   = 17'(right_r) - 17'(left_r);
    sum_abs  = sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
    diff_abs = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);
    n1_full  = sum_abs * circ_r;
    n2_full  = {1'b0, diff_abs[15:0]} * circ_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r    <= n1_full[37:0];
      n2_r    <= n2_full[37:0];
      sneg1_r <= sum_s[16];
      dneg1_r <= diff_s[16];
      imu1_r  <= imu_r;
      prev1_r <= prev_r;
    end
  end

  // ---------------- s2: turn overflow check ----------------
  logic [37:0]        n1_2r, n2_2r;
  logic               cap2_r, sneg2_r, dneg2_r;
  logic signed [31:0] imu2_r, prev2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_2r   <= n1_r;
      n2_2r   <= n2_r;
      cap2_r  <= ({12'd0, n2_r} >= {d_r, 12'd0});
      sneg2_r <= sneg1_r;
      dneg2_r <= dneg1_r;
      imu2_r  <= imu1_r;
      prev2_r <= prev1_r;
    end
  end

  // ---------------- divider chains ----------------
  logic [ODIV_DW-1:0]    orem [ODIV_STEPS+1];
  logic [ODIV_STEPS-1:0] onum [ODIV_STEPS+1];
  logic [ODIV_STEPS-1:0] oquo [ODIV_STEPS+1];
  logic [MDIV_DW-1:0]    mrem [MDIV_STEPS+1];
  logic [MDIV_STEPS-1:0] mnum [MDIV_STEPS+1];
  logic [MDIV_STEPS-1:0] mquo [MDIV_STEPS+1];

  assign orem[0] = {12'd0, n2_2r[37:12]};
  assign onum[0] = {n2_2r[11:0], 28'd0};
  assign oquo[0] = '0;
  assign mrem[0] = '0;
  assign mnum[0] = {n1_2r, 15'd0};
  assign mquo[0] = '0;

  for (genvar g = 0; g < ODIV_STEPS; g++) begin : g_odiv
    ohf_div_cell #(.DW(ODIV_DW), .NW(ODIV_STEPS), .QW(ODIV_STEPS)) u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (d_r),
      .rem_i   (orem[g]),
      .num_i   (onum[g]),
      .quo_i   (oquo[g]),
      .rem_o   (orem[g+1]),
      .num_o   (onum[g+1]),
      .quo_o   (oquo[g+1])
    );
  end

  for (genvar g = 0; g < MDIV_STEPS; g++) begin : g_mdiv
    ohf_div_cell #(.DW(MDIV_DW), .NW(MDIV_STEPS), .QW(MDIV_STEPS)) u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (tpt_eff_r),
      .rem_i   (mrem[g]),
      .num_i   (mnum[g]),
      .quo_i   (mquo[g]),
      .rem_o   (mrem[g+1]),
      .num_o   (mnum[g+1]),
      .quo_o   (mquo[g+1])
    );
  end

  logic [65:0] oside_o;

  ohf_delay #(.W(66), .DEPTH(ODIV_STEPS)) u_oside (
    .clk (clk),
    .en  (en),
    .d_i ({cap2_r, dneg2_r, imu2_r, prev2_r}),
    .d_o (oside_o)
  );

  logic [MDIV_STEPS-1:0] mean_o;
  logic [0:0]            msign_o;

  ohf_delay #(.W(MDIV_STEPS), .DEPTH(MDLY)) u_mean (
    .clk (clk),
    .en  (en),
    .d_i (mquo[MDIV_STEPS]),
    .d_o (mean_o)
  );

  ohf_delay #(.W(1), .DEPTH(SDLY)) u_msign (
    .clk (clk),
    .en  (en),
    .d_i (sneg2_r),
    .d_o (msign_o)
  );

  // ---------------- b1/b2: heading blend ----------------
  logic [40:0]        odo_mag;
  logic signed [41:0] odo_s;
  logic [16:0]        w_imu;
  logic signed [31:0] imu_o, prev_o;
  logic signed [59:0] pa_r, pa_nxt;
  logic signed [49:0] pb_r, pb_nxt;
  logic signed [31:0] prev_b1_r, prev_b2_r;
  logic signed [59:0] fused;
  logic signed [43:0] fused_sh;
  logic signed [31:0] hd_r, hd_nxt;

  always_comb begin
    imu_o   = oside_o[63:32];
    prev_o  = oside_o[31:0];
    odo_mag = oside_o[65] ? (41'd1 << 40) : {1'b0, oquo[ODIV_STEPS]};
    odo_s   = oside_o[64] ? -$signed({1'b0, odo_mag}) : $signed({1'b0, odo_mag});
    w_imu   = 17'd65536 - w_eff_r;
    pa_nxt  = $signed({1'b0, w_eff_r}) * odo_s;
    pb_nxt  = $signed({1'b0, w_imu}) * imu_o;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r      <= pa_nxt;
      pb_r      <= pb_nxt;
      prev_b1_r <= prev_o;
    end
  end

  always_comb begin
    fused    = pa_r + 60'(pb_r) + 60'sd32768;
    fused_sh = 44'(fused >>> 16);
    if (fused_sh > S32_MAX) begin
      hd_nxt = 32'sh7fffffff;
    end else if (fused_sh < S32_MIN) begin
      hd_nxt = 32'sh80000000;
    end else begin
      hd_nxt = 32'(fused_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r      <= hd_nxt;
      prev_b2_r <= prev_b1_r;
    end
  end

  // ---------------- m1..m3: mid heading reduction ----------------
  logic signed [33:0] mid;
  logic signed [31:0] a1_r, a1_nxt;
  logic signed [31:0] a2_r, a2_nxt;
  logic signed [31:0] z0_r, z0_nxt;
  logic               flip_r, flip_nxt;

  always_comb begin
    mid = 34'(prev_b2_r) + 34'(hd_r >>> 1);
    if (mid >= 34'(Q28_TWO_PI)) begin
      a1_nxt = 32'(mid - 34'(Q28_TWO_PI));
    end else if (mid <= -34'(Q28_TWO_PI)) begin
      a1_nxt = 32'(mid + 34'(Q28_TWO_PI));
    end else begin
      a1_nxt = 32'(mid);
    end
  end

  always_comb begin
    if (a1_r > Q28_PI) begin
      a2_nxt = a1_r - Q28_TWO_PI;
    end else if (a1_r < -Q28_PI) begin
      a2_nxt = a1_r + Q28_TWO_PI;
    end else begin
      a2_nxt = a1_r;
    end
  end

  // fold into [-pi/2, pi/2]; the rotation is undone by negating sin/cos
  always_comb begin
    if (a2_r > Q28_HALF_PI) begin
      z0_nxt   = a2_r - Q28_PI;
      flip_nxt = 1'b1;
    end else if (a2_r < -Q28_HALF_PI) begin
      z0_nxt   = a2_r + Q28_PI;
      flip_nxt = 1'b1;
    end else begin
      z0_nxt   = a2_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a1_nxt;
      a2_r   <= a2_nxt;
      z0_r   <= z0_nxt;
      flip_r <= flip_nxt;
    end
  end

  // ---------------- CORDIC row ----------------
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];

  assign cx[0] = XW'(CORDIC_GAIN_Q30);
  assign cy[0] = '0;
  assign cz[0] = z0_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    ohf_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (cx[g]),
      .y_i (cy[g]),
      .z_i (cz[g]),
      .x_o (cx[g+1]),
      .y_o (cy[g+1]),
      .z_o (cz[g+1])
    );
  end

  logic [0:0]  flip_o;
  logic [31:0] hd_o;

  ohf_delay #(.W(1), .DEPTH(CORDIC_STEPS)) u_flip (
    .clk (clk),
    .en  (en),
    .d_i (flip_r),
    .d_o (flip_o)
  );

  ohf_delay #(.W(32), .DEPTH(HDLY)) u_hd (
    .clk (clk),
    .en  (en),
    .d_i (hd_r),
    .d_o (hd_o)
  );

  // ---------------- p1/p2: projection ----------------
  logic signed [XW-1:0]  xf, yf;
  logic [XW-1:0]         xa, ya;
  logic [31:0]           ax_r, ay_r;
  logic                  negx1_r, negy1_r, negx2_r, negy2_r;
  logic [MDIV_STEPS-1:0] m_p1_r;
  logic [52:0]           hx_r, hy_r;
  logic [63:0]           lx_r, ly_r;

  always_comb begin
    xf = flip_o[0] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    yf = flip_o[0] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
    xa = xf[XW-1] ? XW'(-xf) : XW'(xf);
    ya = yf[XW-1] ? XW'(-yf) : XW'(yf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= xa[31:0];
      ay_r    <= ya[31:0];
      negx1_r <= msign_o[0] ^ xf[XW-1];
      negy1_r <= msign_o[0] ^ yf[XW-1];
      m_p1_r  <= mean_o;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hx_r    <= m_p1_r[52:32] * ax_r;
      lx_r    <= m_p1_r[31:0] * ax_r;
      hy_r    <= m_p1_r[52:32] * ay_r;
      ly_r    <= m_p1_r[31:0] * ay_r;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
    end
  end

  // rounded (hi * 2^32 + lo) / 2^46, half away from zero, saturated
  function automatic logic [31:0] proj_round(input logic [52:0] hi,
                                             input logic [63:0] lo,
                                             input logic        neg);
    logic [84:0] s;
    logic [38:0] r;
    logic        big;
    begin
      s   = {hi, 32'd0} + 85'(lo) + (85'd1 << 45);
      r   = s[84:46];
      big = (r >= 39'h80000000);
      if (neg) begin
        proj_round = big ? 32'h80000000 : 32'(-r[31:0]);
      end else begin
        proj_round = big ? 32'h7fffffff : r[31:0];
      end
    end
  endfunction

  logic [ITEM_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && v_r[NSTG-1]) begin
      out_data_r <= {hd_o, proj_round(hy_r, ly_r, negy2_r), proj_round(hx_r, lx_r, negx2_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_cfg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (tpt_eff_r != '0) && (d_r != '0))
    else $error("divisor from configuration is zero");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_M1] |-> ((a1_r < Q28_TWO_PI) && (a1_r > -Q28_TWO_PI)))
    else $error("mid heading not reduced below 2*pi");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_M3] |-> ((z0_r <= Q28_HALF_PI) && (z0_r >= -Q28_HALF_PI)))
    else $error("CORDIC angle outside +/- pi/2");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && v_r[NSTG-1]))
    else $error("input stalled without a held result");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for odometry_imu_heading_fusion
// Sends encoder/IMU items through the stream port under random source gaps
// and sink stalls. Each result is checked against a fixed value (chk rows)
// or a fixed-point predictor of wheel distances, heading blend and projection.
// Register settings change between phases while the pipe is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import ohf_pkg::*;

  typedef longint unsigned u64_t;

  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN_CYC  = 120;   // above the DUT's NSTG pipeline stages
  localparam int N_PHASE    = 8;
  localparam int PHASE_ITEMS = 130;

  localparam longint TWO_PI_Q28  = 64'sd1686629713;
  localparam longint PI_Q28      = 64'sd843314857;
  localparam longint HALF_PI_Q28 = 64'sd421657428;
  localparam longint QTR_PI_Q28  = 64'sd210828714;
  localparam longint GAIN_Q30    = 64'sd652032875;
  localparam longint TURN_CAP    = 64'sd1 << 40;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ITEM_W-1:0]   in_tdata;   // left_ticks, right_ticks, imu_yaw_delta, prev_heading
  logic                out_tvalid;
  logic                out_tready;
  logic [ITEM_W-1:0]   out_tdata;  // move_x_um, move_y_um, heading_delta
  logic                cfg_wr_en;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wr_data;

  odometry_imu_heading_fusion dut (.*);

  // register copies used for prediction
  logic [16:0] weight_q16;
  logic [15:0] ticks_turn;
  logic [21:0] circ_um;
  logic [21:0] spacing_um;

  logic [ITEM_W-1:0] motion_q[$];
  int  n_err;
  int  n_sent;
  int  n_recv;
  bit  steady;   // no gaps or stalls while set

  typedef struct packed {
    logic              chk;
    logic [15:0]       lt;
    logic [15:0]       rt;
    logic [31:0]       imu;
    logic [31:0]       prv;
    logic [ITEM_W-1:0] res;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS[16] = '{
    '{1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 96'h0},
    '{1'b1, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 96'h0},
    '{1'b1, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 96'h0},
    '{1'b0, 16'h7FFF, 16'h7FFF, 32'h0000_0000, 32'h0000_0000, 96'h0},
    '{1'b0, 16'h8000, 16'h8000, 32'h0000_0000, 32'h0000_0000, 96'h0},
    '{1'b0, 16'h8000, 16'h7FFF, 32'h0000_0000, 32'h3243_F6A9, 96'h0},
    '{1'b0, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 32'hCDBC_0957, 96'h0},
    '{1'b0, 16'h0100, 16'h0100, 32'h0000_0000, 32'h1921_FB54, 96'h0},
    '{1'b0, 16'h0100, 16'h0100, 32'h0000_0000, 32'hE6DE_04AC, 96'h0},
    '{1'b0, 16'h0100, 16'h0100, 32'h0000_0000, 32'h7FFF_FFFF, 96'h0},
    '{1'b0, 16'h0100, 16'h0100, 32'h0000_0000, 32'h8000_0000, 96'h0},
    '{1'b0, 16'h0001, 16'hFFFF, 32'h1234_5678, 32'h0000_0001, 96'h0},
    '{1'b0, 16'hFFFF, 16'h0001, 32'h0000_0000, 32'hFFFF_FFFF, 96'h0},
    '{1'b0, 16'h7FFF, 16'h0000, 32'h0000_0000, 32'h6487_ED51, 96'h0},
    '{1'b0, 16'h0000, 16'h7FFF, 32'h0000_0000, 32'h9B78_12AF, 96'h0},
    '{1'b0, 16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 96'h0}
  };

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint acc;
    longint term;
    int     k;
    bit     neg;
    acc = 0;
    neg = 0;
    if (i == 0) return QTR_PI_Q28;
    for (k = 1; i * k <= 60; k += 2) begin
      term = longint'(64'd1 << (60 - i * k)) / longint'(k);
      acc  = neg ? acc - term : acc + term;
      neg  = !neg;
    end
    return longint'((u64_t'(acc) + (64'd1 << 31)) >> 32);
  endfunction

  // rounded, saturated (m * t) / 2^46
  function automatic longint scale_dist(longint m, longint t);
    bit neg;
    longint unsigned um, ut, p, q, r;
    longint s;
    neg = (m < 0) != (t < 0);
    um  = m < 0 ? -m : m;
    ut  = t < 0 ? -t : t;
    p   = (um >> 32) * ut;
    q   = (um & 64'hFFFF_FFFF) * ut + (64'd1 << 45);
    r   = (p >> 14) + ((((p & 64'h3FFF) << 32) + q) >> 46);
    if (r > 64'h8000_0000) r = 64'h8000_0000;
    s = neg ? -longint'(r) : longint'(r);
    return clamp32(s);
  endfunction

  function automatic logic [ITEM_W-1:0] predict_motion(logic [ITEM_W-1:0] d);
    longint lt, rt, imu, prv, tpt, spc, circ, w, sm, df;
    longint mean, odo, fused, hd, a, x, y, z, xs, ys, at;
    longint sx, sy;
    longint unsigned n, dv, qq, rr;
    bit flip;
    lt   = longint'($signed(d[15:0]));
    rt   = longint'($signed(d[31:16]));
    imu  = longint'($signed(d[63:32]));
    prv  = longint'($signed(d[95:64]));
    tpt  = ticks_turn == 0 ? 1 : longint'(ticks_turn);
    spc  = spacing_um == 0 ? 1 : longint'(spacing_um);
    circ = longint'(circ_um);
    w    = weight_q16 > 17'd65536 ? 65536 : longint'(weight_q16);
    sm   = lt + rt;
    df   = rt - lt;
    flip = 0;

    n    = u64_t'(sm < 0 ? -sm : sm) * u64_t'(circ);
    mean = longint'((n << 15) / u64_t'(tpt));
    if (sm < 0) mean = -mean;

    n  = u64_t'(df < 0 ? -df : df) * u64_t'(circ);
    dv = u64_t'(tpt) * u64_t'(spc);
    qq = n / dv;
    rr = n % dv;
    if (qq >= 64'd4096) begin
      qq = TURN_CAP;
    end else begin
      for (int i = 0; i < 28; i++) begin
        rr = rr << 1;
        qq = qq << 1;
        if (rr >= dv) begin
          rr = rr - dv;
          qq = qq | 64'd1;
        end
      end
      if (qq > TURN_CAP) qq = TURN_CAP;
    end
    odo = df < 0 ? -longint'(qq) : longint'(qq);

    fused = w * odo + (65536 - w) * imu;
    hd    = clamp32((fused + 32768) >>> 16);

    // mid heading into [-pi/2, pi/2], remembering a half-turn fold
    a = (prv + (hd >>> 1)) % TWO_PI_Q28;
    if (a > PI_Q28) a -= TWO_PI_Q28;
    if (a < -PI_Q28) a += TWO_PI_Q28;
    if (a > HALF_PI_Q28) begin
      a -= PI_Q28;
      flip = 1;
    end else if (a < -HALF_PI_Q28) begin
      a += PI_Q28;
      flip = 1;
    end

    x = GAIN_Q30;
    y = 0;
    z = a;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      at = atan_step(i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= at;
      end else begin
        x += ys; y -= xs; z += at;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sx = scale_dist(mean, x);
    sy = scale_dist(mean, y);
    return {hd[31:0], sy[31:0], sx[31:0]};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // source side: one item, random gap ahead of it, then wait for accept
  task automatic send_item(logic [ITEM_W-1:0] d, bit typed, logic [ITEM_W-1:0] res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    motion_q.push_back(typed ? res : predict_motion(d));
    n_sent++;
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val[CFG_DW-1:0];
    @(posedge clk);
    case (idx)
      CFG_ODO_WEIGHT:     weight_q16 = val[16:0];
      CFG_TICKS_PER_TURN: ticks_turn = val[15:0];
      CFG_WHEEL_CIRC:     circ_um    = val[21:0];
      default:            spacing_um = val[21:0];
    endcase
  endtask

  function automatic logic [ITEM_W-1:0] rand_item(int mode);
    logic [15:0] lt, rt;
    logic [31:0] imu, prv;
    prv = $urandom;
    imu = $urandom;
    if (mode == 0) begin
      lt = $urandom;
      rt = $urandom;
    end else begin
      // typical motion: small tick counts, small yaw
      lt  = 16'($signed($urandom_range(0, 400)) - 200);
      rt  = 16'($signed($urandom_range(0, 400)) - 200);
      imu = 32'($signed(imu) >>> $urandom_range(4, 20));
    end
    return {prv, imu, rt, lt};
  endfunction

  // sink side
  initial begin
    int stall;
    logic [ITEM_W-1:0] exp_v;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_recv++;
      if (motion_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected item %h", out_tdata);
      end else begin
        exp_v = motion_q.pop_front();
        if (out_tdata[31:0] !== exp_v[31:0] || out_tdata[63:32] !== exp_v[63:32] ||
            out_tdata[95:64] !== exp_v[95:64]) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: item %0d dx %h/%h dy %h/%h hd %h/%h (exp/got)", n_recv,
                     exp_v[31:0], out_tdata[31:0], exp_v[63:32], out_tdata[63:32],
                     exp_v[95:64], out_tdata[95:64]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  int idle_cyc;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("timeout with %0d items outstanding", motion_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    int unsigned w_set[N_PHASE];
    int unsigned t_set[N_PHASE];
    int unsigned c_set[N_PHASE];
    int unsigned s_set[N_PHASE];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = CFG_ODO_WEIGHT;
    cfg_wr_data = '0;
    n_err       = 0;
    n_sent      = 0;
    n_recv      = 0;
    idle_cyc    = 0;
    steady      = 0;
    weight_q16  = 17'd65536;
    ticks_turn  = 16'd4096;
    circ_um     = 22'd200000;
    spacing_um  = 22'd300000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i])
      send_item({DIR_ROWS[i].prv, DIR_ROWS[i].imu, DIR_ROWS[i].rt, DIR_ROWS[i].lt},
                DIR_ROWS[i].chk, DIR_ROWS[i].res);

    // fixed corner settings first, then random ones
    w_set = '{0, 65536, 131071, 32768, 1, 0, 0, 0};
    t_set = '{1, 65535, 0, 4096, 1, 0, 0, 0};
    c_set = '{4000000, 1, 4194303, 0, 4194303, 0, 0, 0};
    s_set = '{1, 4000000, 0, 4194303, 4000000, 0, 0, 0};
    for (int ph = 5; ph < N_PHASE; ph++) begin
      w_set[ph] = $urandom_range(0, 65536);
      t_set[ph] = $urandom_range(1, 65535);
      c_set[ph] = $urandom_range(1, 4000000);
      s_set[ph] = $urandom_range(1, 4000000);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain_pipe();
      write_reg(CFG_ODO_WEIGHT, w_set[ph]);
      write_reg(CFG_TICKS_PER_TURN, t_set[ph]);
      write_reg(CFG_WHEEL_CIRC, c_set[ph]);
      write_reg(CFG_WHEEL_SPACING, s_set[ph]);
      cfg_wr_en <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_item(rand_item($urandom_range(0, 1)), 1'b0, '0);
      end
      steady = 0;
    end

    drain_pipe();
    $display("sent %0d items, checked %0d results over %0d register settings",
             n_sent, n_recv, N_PHASE + 1);
    $display("mismatches: %0d", n_err);
    if (n_err == 0 && motion_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
